### src/wpnr_pkg.sv
// shared types and constants for the weighted pick block
package wpnr_pkg;

  // default table capacity
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // field widths
  localparam int unsigned CNT_CFG_W = 5;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned WGT_W     = 8;
  localparam int unsigned RND_W     = 31;

  // weight total width: at most 31 slots of weight 255
  localparam int unsigned TOT_W = 13;

  // table word: id over weight
  localparam int unsigned ENTRY_W = ID_W + WGT_W;

  // item opcodes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SELECT = 1'b1
  } op_e;

  // one result beat
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } res_t;

endpackage

### src/wpnr_ram.sv
// generic single write, single read ram with registered read
module wpnr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/wpnr_mod.sv
// serial restoring modulo unit, one quotient bit per cycle
module wpnr_mod import wpnr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RND_W-1:0] dividend_i,
  input  logic [TOT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [TOT_W-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(RND_W + 1);

  logic             busy_q, busy_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0] div_q, div_d;
  logic [TOT_W-1:0] dvs_q, dvs_d;
  logic [TOT_W-1:0] rem_q, rem_d;
  logic [TOT_W:0]   rem_sh;
  logic [TOT_W:0]   rem_sub;

  // shared compare and subtract step
  assign rem_sh  = {rem_q, div_q[RND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(RND_W);
      div_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        div_d = {div_q[RND_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = rem_sub[TOT_W-1:0];
        end else begin
          rem_d = rem_sh[TOT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

### src/wpnr_seq.sv
// select sequencer: weight sum pass, modulo, walk pass, slot zero fallback and result hold
module wpnr_seq import wpnr_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF,
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int unsigned CntW = $clog2(MaxEntries + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RND_W-1:0]     random_i,
  input  logic [CNT_CFG_W-1:0] count_i,
  output logic                 idle_o,
  output logic [IdxW-1:0]      rd_addr_o,
  input  logic [ENTRY_W-1:0]   rd_data_i,
  output logic                 mod_start_o,
  output logic [RND_W-1:0]     mod_dividend_o,
  output logic [TOT_W-1:0]     mod_divisor_o,
  input  logic                 mod_done_i,
  input  logic [TOT_W-1:0]     mod_rem_i,
  output logic                 fin_valid_o,
  input  logic                 fin_ready_i,
  output res_t                 fin_res_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_MOD  = 7'b0000100,
    ST_WALK = 7'b0001000,
    ST_ZERO = 7'b0010000,
    ST_ZDAT = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  pend_idx_q, pend_idx_d;
  logic [TOT_W-1:0] acc_q, acc_d;
  logic [ID_W-1:0]  last_id_q, last_id_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  res_t             res_q, res_d;

  logic [CntW-1:0]  n_clamp;
  logic             issue_more;
  logic [ID_W-1:0]  rid;
  logic [TOT_W-1:0] rwgt;
  logic             excl;

  // slots in use, capped at capacity
  assign n_clamp = (32'(count_i) > MaxEntries) ? CntW'(MaxEntries) : CntW'(count_i);

  // table read data of the entry in flight
  assign rid        = rd_data_i[ENTRY_W-1:WGT_W];
  assign rwgt       = TOT_W'(rd_data_i[WGT_W-1:0]);
  assign excl       = (rid == last_id_q);
  assign issue_more = (issue_q < n_q);

  assign rd_addr_o = (state_q == ST_ZERO) ? '0 : issue_q[IdxW-1:0];

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    acc_d       = acc_q;
    last_id_d   = last_id_q;
    rnd_d       = rnd_q;
    res_d       = res_q;
    mod_start_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rnd_d   = random_i;
          n_d     = n_clamp;
          issue_d = '0;
          pend_d  = 1'b0;
          acc_d   = '0;
          if (n_clamp == '0) begin
            res_d   = '0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        pend_d     = issue_more;
        pend_idx_d = issue_q;
        if (issue_more) begin
          issue_d = issue_q + 1'b1;
        end
        if (pend_q && !excl) begin
          acc_d = acc_q + rwgt;
        end
        if (!issue_more && !pend_q) begin
          if (acc_q == '0) begin
            state_d = ST_ZERO;
          end else begin
            mod_start_o = 1'b1;
            state_d     = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done_i) begin
          acc_d   = mod_rem_i;
          issue_d = '0;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        pend_d     = issue_more;
        pend_idx_d = issue_q;
        if (issue_more) begin
          issue_d = issue_q + 1'b1;
        end
        if (pend_q && !excl) begin
          if (rwgt > acc_q) begin
            res_d.found = 1'b1;
            res_d.slot  = SLOT_W'(pend_idx_q);
            res_d.id    = rid;
            last_id_d   = rid;
            state_d     = ST_FIN;
          end else begin
            acc_d = acc_q - rwgt;
          end
        end else if (!issue_more && !pend_q) begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        state_d = ST_ZDAT;
      end
      ST_ZDAT: begin
        res_d.found = 1'b1;
        res_d.slot  = '0;
        res_d.id    = rid;
        last_id_d   = rid;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (fin_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      n_q        <= '0;
      issue_q    <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      acc_q      <= '0;
      last_id_q  <= '0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      issue_q    <= issue_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      acc_q      <= acc_d;
      last_id_q  <= last_id_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    res_q <= res_d;
  end

  assign idle_o         = (state_q == ST_IDLE);
  assign mod_dividend_o = rnd_q;
  assign mod_divisor_o  = acc_q;
  assign fin_valid_o    = (state_q == ST_FIN);
  assign fin_res_o      = res_q;

endmodule

### src/weighted_pick_no_repeat.sv
// top level of the weighted pick without repeat block
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+-------------------------------
//   in       | sink      | in_valid_i / in_stall_o | opcode, slot, id, weight, random
//   out      | source    | out_valid_o / out_stall_i | found, chosen_slot, chosen_id
//   cfg      | sink      | cfg_valid_i / cfg_ready_o | entry_count
//
// a load beat writes the table; the block is ready again next cycle.
// a select beat stalls the input until the sequencer is idle again: a sum pass over the n
// slots in use and a walk pass over up to n slots, both through the one registered
// read port, the serial modulo unit between them, and a result state. an empty table
// goes straight to the result state.
// reset clears the entry count and last id. a stalled result waits in the output
// register; one more select can finish behind it, then the input stalls.
module weighted_pick_no_repeat import wpnr_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [WGT_W-1:0]     entry_weight_i,
  input  logic [RND_W-1:0]     random_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [SLOT_W-1:0]    chosen_slot_o,
  output logic [ID_W-1:0]      chosen_id_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CNT_CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [CNT_CFG_W-1:0] count_q;
  logic                 in_accept;
  logic                 sel_start;
  logic                 ram_we;
  logic [IdxW-1:0]      rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 seq_idle;
  logic                 mod_start;
  logic [RND_W-1:0]     mod_dividend;
  logic [TOT_W-1:0]     mod_divisor;
  logic                 mod_done;
  logic [TOT_W-1:0]     mod_rem;
  logic                 fin_valid;
  logic                 out_free;
  res_t                 fin_res;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_res_q;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // input beat decode
  assign in_stall_o = !seq_idle;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign sel_start  = in_accept && (opcode_i == OP_SELECT);
  assign ram_we     = in_accept && (opcode_i == OP_LOAD) && (32'(slot_i) < MaxEntries);

  // entry table
  wpnr_ram #(
    .Width (ENTRY_W),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(slot_i)),
    .wdata_i ({entry_id_i, entry_weight_i}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // serial modulo unit
  wpnr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // select sequencer
  wpnr_seq #(
    .MaxEntries (MaxEntries)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (sel_start),
    .random_i       (random_value_i),
    .count_i        (count_q),
    .idle_o         (seq_idle),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .mod_start_o    (mod_start),
    .mod_dividend_o (mod_dividend),
    .mod_divisor_o  (mod_divisor),
    .mod_done_i     (mod_done),
    .mod_rem_i      (mod_rem),
    .fin_valid_o    (fin_valid),
    .fin_ready_i    (out_free),
    .fin_res_o      (fin_res)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && out_free) begin
      out_res_q <= fin_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_res_q.found;
  assign chosen_slot_o = out_res_q.slot;
  assign chosen_id_o   = out_res_q.id;

`ifndef ASSERT_OFF
  // a select beat keeps the block busy on the next cycle
  a_select_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (opcode_i == OP_SELECT) |=> in_stall_o)
    else $error("select beat did not start the sequencer");

  // a load beat leaves the block ready on the next cycle
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (opcode_i == OP_LOAD) |=> !in_stall_o)
    else $error("load beat stalled the input");

  // an empty-table answer carries zero slot and id
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (chosen_slot_o == '0) && (chosen_id_o == '0))
    else $error("empty-table result with nonzero fields");
`endif

endmodule

### tb/sv/tb_weighted_pick_no_repeat.sv
// self-checking testbench for the weighted pick without repeat block
`timescale 1ns / 100ps

module tb_weighted_pick_no_repeat;
  import wpnr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned IDLE_TAIL   = 80;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PICK_DEPTH  = 64;

  // dut signals
  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 opcode_i       = OP_LOAD;
  logic [SLOT_W-1:0]    slot_i         = '0;
  logic [ID_W-1:0]      entry_id_i     = '0;
  logic [WGT_W-1:0]     entry_weight_i = '0;
  logic [RND_W-1:0]     random_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 found_o;
  logic [SLOT_W-1:0]    chosen_slot_o;
  logic [ID_W-1:0]      chosen_id_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CNT_CFG_W-1:0] cfg_data_i     = '0;

  // predictor state
  logic [ID_W-1:0]  tbl_id  [MAX_ENTRIES_DEF];
  logic [WGT_W-1:0] tbl_wgt [MAX_ENTRIES_DEF];
  logic [ID_W-1:0]  last_id = '0;
  int unsigned      slots_in_use = 0;

  // expected picks, oldest first, in a ring
  res_t        pick_buf [PICK_DEPTH];
  logic [5:0]  pick_wr  = '0;
  logic [5:0]  pick_rd  = '0;
  int unsigned pick_cnt = 0;

  int unsigned error_cnt   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_cycles = 0;
  bit          in_idle_on  = 1'b0;
  bit          out_idle_on = 1'b0;

  weighted_pick_no_repeat u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .entry_id_i     (entry_id_i),
    .entry_weight_i (entry_weight_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .chosen_slot_o  (chosen_slot_o),
    .chosen_id_o    (chosen_id_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_weighted_pick_no_repeat NOT OK");
    $finish;
  end

  // roulette pick over the slots in use, skipping the last chosen id
  function automatic res_t predict_pick(logic [RND_W-1:0] rnd);
    res_t        r;
    int unsigned n;
    int unsigned total;
    int unsigned rem;
    bit          hit;
    r = '0;
    n = (slots_in_use > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : slots_in_use;
    if (n == 0) return r;
    total = 0;
    for (int i = 0; i < n; i++)
      if (tbl_id[i] != last_id) total += tbl_wgt[i];
    r.found = 1'b1;
    r.slot  = '0;
    // a zero total falls back to slot zero
    if (total != 0) begin
      rem = (int'(rnd) % total) + 1;
      hit = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        if (tbl_id[i] != last_id) begin
          if (rem <= tbl_wgt[i]) begin
            r.slot = SLOT_W'(i);
            hit    = 1'b1;
          end else begin
            rem -= tbl_wgt[i];
          end
        end
      end
    end
    r.id    = tbl_id[r.slot];
    last_id = r.id;
    return r;
  endfunction

  function automatic void note_error(string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // send one beat on the input channel; mirror a load in the table or predict a select's result
  task automatic send_beat(op_e op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                           logic [WGT_W-1:0] wgt, logic [RND_W-1:0] rnd);
    int unsigned gap;
    bit          taken;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    slot_i         <= slot;
    entry_id_i     <= id;
    entry_weight_i <= wgt;
    random_value_i <= rnd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (op == OP_LOAD) begin
      tbl_id[slot]  = id;
      tbl_wgt[slot] = wgt;
    end else begin
      pick_buf[pick_wr] = predict_pick(rnd);
      pick_wr++;
      pick_cnt++;
    end
  endtask

  // drop valid, wait for every pick, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pick_cnt != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  // entry count write, only while idle
  task automatic write_count(logic [CNT_CFG_W-1:0] cnt);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i  <= 1'b0;
    slots_in_use = cnt;
    @(posedge clk_i);
  endtask

  // result side: random stall, long hold on request, check each beat
  initial begin : result_check
    int unsigned k;
    bit          taken;
    res_t        got;
    res_t        want;
    forever begin
      if (hold_cycles != 0) begin
        k           = hold_cycles;
        hold_cycles = 0;
      end else begin
        k = out_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (k != 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        taken     = (out_valid_o === 1'b1);
        got.found = found_o;
        got.slot  = chosen_slot_o;
        got.id    = chosen_id_o;
        @(posedge clk_i);
      end
      if (pick_cnt == 0) begin
        note_error($sformatf("unexpected beat found=%0b slot=%0d id=%h",
                             got.found, got.slot, got.id));
      end else begin
        want = pick_buf[pick_rd];
        pick_rd++;
        pick_cnt--;
        if (got.found !== want.found || got.slot !== want.slot || got.id !== want.id)
          note_error($sformatf("exp found=%0b slot=%0d id=%h, got found=%0b slot=%0d id=%h",
                               want.found, want.slot, want.id,
                               got.found, got.slot, got.id));
      end
    end
  end

  // random field values biased toward extremes and repeated ids
  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(0, 3))
      0:       return ID_W'($urandom);
      1:       return '1;
      default: return ID_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight(bit sparse);
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return (sparse && $urandom_range(0, 3) != 0) ? '0 : WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [RND_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RND_W'($urandom);
    endcase
  endfunction

  // select on an empty table right after reset
  task automatic test_empty_table();
    write_count('0);
    send_beat(OP_SELECT, '0, '0, '0, '0);
    send_beat(OP_SELECT, '1, '1, '1, '1);
    wait_idle();
  endtask

  // load every slot, with id and weight extremes among them
  task automatic test_load_table();
    for (int i = 0; i < MAX_ENTRIES_DEF; i++)
      send_beat(OP_LOAD, SLOT_W'(i),
                (i == MAX_ENTRIES_DEF - 1) ? 16'hFFFF : ID_W'(i * 16'h0101),
                (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : WGT_W'(i * 16),
                RND_W'($urandom));
    wait_idle();
  endtask

  // full table, random extremes, back-to-back picks exclude the last id
  task automatic test_select_extremes();
    write_count(CNT_CFG_W'(MAX_ENTRIES_DEF));
    send_beat(OP_SELECT, '0, '0, '0, '0);
    send_beat(OP_SELECT, '1, '1, '1, '1);
    send_beat(OP_SELECT, '0, '0, '0, '1);
    wait_idle();
  endtask

  // one slot of weight zero gives a zero total
  task automatic test_zero_total();
    write_count(CNT_CFG_W'(1));
    send_beat(OP_SELECT, '0, '0, '0, RND_W'(12345));
    send_beat(OP_SELECT, '0, '0, '0, '1);
    wait_idle();
  endtask

  // counts beyond the table size clamp to a full table
  task automatic test_over_capacity();
    write_count('1);
    send_beat(OP_SELECT, '0, '0, '0, RND_W'($urandom));
    send_beat(OP_SELECT, '0, '0, '0, RND_W'($urandom));
    wait_idle();
    write_count(CNT_CFG_W'(MAX_ENTRIES_DEF + 1));
    send_beat(OP_SELECT, '0, '0, '0, RND_W'($urandom));
    wait_idle();
  endtask

  // phases of random loads and selects under varied counts and idling
  task automatic test_random();
    bit sparse;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_count(CNT_CFG_W'(MAX_ENTRIES_DEF));
        1:       write_count('0);
        2:       write_count('1);
        3:       write_count(CNT_CFG_W'(1));
        4:       write_count(CNT_CFG_W'(MAX_ENTRIES_DEF + 1));
        default: write_count(CNT_CFG_W'($urandom_range(2, MAX_ENTRIES_DEF)));
      endcase
      in_idle_on  = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom);
      out_idle_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom);
      sparse      = (p % 3 == 2);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 9) < 4)
          send_beat(OP_LOAD, SLOT_W'($urandom), rand_id(), rand_weight(sparse),
                    RND_W'($urandom));
        else
          send_beat(OP_SELECT, SLOT_W'($urandom), ID_W'($urandom), WGT_W'($urandom),
                    rand_value());
      end
      wait_idle();
    end
  endtask

  // long output hold while selects keep coming, then a pause and a restart
  task automatic test_backpressure();
    write_count(CNT_CFG_W'(MAX_ENTRIES_DEF));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      send_beat(OP_SELECT, '0, '0, '0, rand_value());
    wait_idle();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    for (int i = 0; i < 10; i++)
      send_beat(OP_SELECT, '0, '0, '0, rand_value());
    wait_idle();
  endtask

  // test sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_load_table();
    test_select_extremes();
    test_zero_total();
    test_over_capacity();
    test_random();
    test_backpressure();
    if (error_cnt == 0) begin
      $display("tb_weighted_pick_no_repeat OK");
    end else begin
      $display("tb_weighted_pick_no_repeat NOT OK");
    end
    $finish;
  end

endmodule
